@@ sv/hmf_pkg.sv @@
package hmf_pkg;

   localparam int KEY_BITS_DEFAULT   = 8;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int KEY_FIELD_BITS   = 8;
   localparam int COUNT_FIELD_BITS = 16;

   typedef struct packed {
      logic [KEY_FIELD_BITS-1:0] key_value;
      logic                      last_item;
   } hmf_req_type;

   typedef struct packed {
      logic [KEY_FIELD_BITS-1:0]   mode_value;
      logic [COUNT_FIELD_BITS-1:0] mode_count;
   } hmf_rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } hmf_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_write;
      logic capture;
      logic update;
   } hmf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic last_item;
      logic rsp_busy;
   } hmf_status_type;

endpackage

@@ sv/hmf_ctrl.sv @@
module hmf_ctrl
   import hmf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  hmf_status_type status,
   output hmf_cmd_type    cmd
);

   hmf_state_type state_ff;
   hmf_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // A closing beat waits until the result register is free.
            if (!(status.last_item && status.rsp_busy)) begin
               cmd.update = 1'b1;
               state_in   = status.last_item ? ST_CLEAR : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

@@ sv/hmf_datapath.sv @@
module hmf_datapath
   import hmf_pkg::*;
#(
   parameter int KEY_BITS   = KEY_BITS_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  hmf_req_type    req_data,
   input  hmf_cmd_type    cmd,
   output hmf_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output hmf_rsp_type    rsp_data
);

   localparam int DEPTH = 1 << KEY_BITS;

   logic [COUNT_BITS-1:0] count_mem [DEPTH];

   logic [KEY_BITS-1:0]   clear_ptr_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic                  last_ff;
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic [KEY_BITS-1:0]   best_key_ff;
   logic [COUNT_BITS-1:0] best_count_ff;
   logic                  rsp_valid_ff;
   hmf_rsp_type           rsp_data_ff;

   logic [KEY_BITS+KEY_FIELD_BITS-1:0]     key_in_ext;
   logic [KEY_BITS-1:0]                    key_in;
   logic [COUNT_BITS-1:0]                  count_inc;
   logic                                   better;
   logic [KEY_BITS-1:0]                    new_best_key;
   logic [COUNT_BITS-1:0]                  new_best_count;
   logic [KEY_BITS+KEY_FIELD_BITS-1:0]     best_key_ext;
   logic [COUNT_BITS+COUNT_FIELD_BITS-1:0] best_count_ext;
   logic [KEY_BITS-1:0]                    wr_addr;
   logic [COUNT_BITS-1:0]                  wr_data;

   // Keys wider than the store wrap to their low bits.
   assign key_in_ext = {{KEY_BITS{1'b0}}, req_data.key_value};
   assign key_in     = key_in_ext[KEY_BITS-1:0];

   assign count_inc = (rd_data_ff == {COUNT_BITS{1'b1}}) ? rd_data_ff
                                                          : rd_data_ff + 1'b1;
   assign better    = (count_inc > best_count_ff) ||
                      ((count_inc == best_count_ff) && (key_ff < best_key_ff));
   assign new_best_key   = better ? key_ff : best_key_ff;
   assign new_best_count = better ? count_inc : best_count_ff;

   assign best_key_ext   = {{KEY_FIELD_BITS{1'b0}}, new_best_key};
   assign best_count_ext = {{COUNT_FIELD_BITS{1'b0}}, new_best_count};

   assign wr_addr = cmd.clear_write ? clear_ptr_ff : key_ff;
   assign wr_data = cmd.clear_write ? '0 : count_inc;

   always_ff @(posedge clock) begin
      if (cmd.clear_write || cmd.update) begin
         count_mem[wr_addr] <= wr_data;
      end
      if (cmd.capture) begin
         rd_data_ff <= count_mem[key_in];
         key_ff     <= key_in;
         last_ff    <= req_data.last_item;
      end
      if (cmd.update && last_ff) begin
         rsp_data_ff.mode_value <= best_key_ext[KEY_FIELD_BITS-1:0];
         rsp_data_ff.mode_count <= best_count_ext[COUNT_FIELD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ptr_ff  <= '0;
         best_key_ff   <= '0;
         best_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.clear_write) begin
            clear_ptr_ff <= clear_ptr_ff + 1'b1;
         end
         if (cmd.update) begin
            if (last_ff) begin
               best_key_ff   <= '0;
               best_count_ff <= '0;
            end else begin
               best_key_ff   <= new_best_key;
               best_count_ff <= new_best_count;
            end
         end
         if (cmd.update && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.clear_done = (clear_ptr_ff == {KEY_BITS{1'b1}});
   assign status.last_item  = last_ff;
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // At most one datapath action per cycle; the store has one write port.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_write, cmd.capture, cmd.update}))
      else $error("conflicting datapath commands");

   // A beat is read and then updated, never captured twice in a row.
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !cmd.capture)
      else $error("back-to-back capture");

   // A closing beat leaves the running best cleared for the next set.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.update && last_ff) |=> (best_count_ff == '0) && (best_key_ff == '0))
      else $error("running best not cleared after a set");

   // A closing beat never overwrites a result that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.update && last_ff) |-> !(rsp_valid_ff && !rsp_ready))
      else $error("pending result overwritten");

endmodule

@@ sv/histogram_mode_finder.sv @@
// Each key beat is a store read, then a count update; the result of a set
// is valid in the cycle after its closing beat's update.
// A new key waits until the last one is written back: the store has a single port.
// After each set, and after reset, a clear pass over every store entry runs before new keys.
// Reset (synchronous, active high) empties the result register and starts the clear pass.
module histogram_mode_finder
   import hmf_pkg::*;
#(
   parameter int KEY_BITS   = KEY_BITS_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  hmf_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output hmf_rsp_type rsp_data
);

   // The controller sequences the clear pass, the read of a key's count and the
   // write-back of the incremented count. The datapath holds the count store, the
   // running best (key, count) and the result register.
   hmf_cmd_type    cmd;
   hmf_status_type status;

   hmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The result register lets the next set's clear pass and keys proceed while a
   // finished result beat still waits to be taken.
   hmf_datapath #(
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/sv/histogram_mode_finder_tb.sv @@
// Self-checking bench for the histogram mode finder. Keys stream in as request
// beats, and a beat with last_item set closes the set. Each closing beat must
// produce one response beat that carries the most frequent key of the set and
// its count. The bench keeps its own key tally. It predicts every response
// and compares each response beat, field by field, against the oldest
// prediction. Both channels idle at random, and some stretches run with no
// idling at all.
module histogram_mode_finder_tb;
   import hmf_pkg::*;

   // Tally limits follow the build parameters that the instance uses.
   localparam int                KEY_DEPTH   = 1 << KEY_BITS_DEFAULT;
   localparam longint unsigned   TALLY_MAX   = (64'd1 << COUNT_BITS_DEFAULT) - 64'd1;
   // The block runs a clear pass over every store entry after reset and
   // after each set. A long receiver stall can add to that, and so can a
   // long sender gap. The watchdog limit covers all of these several times.
   localparam int                STALL_LIMIT = 4000;
   // Quiet time at the end. It covers the result latency and a full clear
   // pass, so any stray response beat still shows up.
   localparam int                DRAIN_CYCLES = KEY_DEPTH + 64;
   localparam int                RANDOM_KEYS = 840;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   hmf_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   hmf_rsp_type rsp_data;

   histogram_mode_finder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Mode predictor: its own count per key and the running leader.
   // ---------------------------------------------------------------------
   longint unsigned key_tally [KEY_DEPTH];
   int              lead_key;
   longint unsigned lead_count;
   hmf_rsp_type     expected_modes [$];
   int              error_count = 0;

   task automatic clear_tally();
      foreach (key_tally[i]) key_tally[i] = 0;
      lead_key   = 0;
      lead_count = 0;
   endtask

   // Count one accepted key. A closing beat queues the mode of its set. The
   // queued value is the typed-in one when a table row gives it, and else the
   // one computed here. The tally is then cleared, just as the block clears
   // its store.
   task automatic tally_key(input hmf_req_type beat, input bit typed,
                            input hmf_rsp_type typed_mode);
      int          k;
      hmf_rsp_type mode;
      // Only the low KEY_BITS bits of the key index the store.
      k = int'(beat.key_value) % KEY_DEPTH;
      if (key_tally[k] < TALLY_MAX) key_tally[k]++;
      // A larger count takes the lead. On an equal count the smaller key wins.
      if (key_tally[k] > lead_count || (key_tally[k] == lead_count && k < lead_key)) begin
         lead_count = key_tally[k];
         lead_key   = k;
      end
      if (beat.last_item) begin
         mode.mode_value = lead_key[KEY_FIELD_BITS-1:0];
         mode.mode_count = lead_count[COUNT_FIELD_BITS-1:0];
         expected_modes.push_back(typed ? typed_mode : mode);
         clear_tally();
      end
   endtask

   // ---------------------------------------------------------------------
   // Request side. The gap before each beat is picked here. Calm stretches
   // send keys back to back. Other stretches mix many short gaps with a few
   // long ones.
   // ---------------------------------------------------------------------
   bit sender_calm = 1'b0;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (sender_calm || roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 8);
      return $urandom_range(10, 40);
   endfunction

   // Drive one key beat and hold it until the block accepts it. The task is
   // entered just after a rising edge. With no gap, valid stays high into the
   // next beat, so the signal never gets two assignments in one time step.
   task automatic send_key(input hmf_req_type beat, input int gap, input bit typed,
                           input hmf_rsp_type typed_mode);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tally_key(beat, typed, typed_mode);
   endtask

   // ---------------------------------------------------------------------
   // Response side. Ready is dropped for runs of cycles. Calm phases never
   // stall. Other phases often stall for short runs, and now and then
   // for long ones.
   // ---------------------------------------------------------------------
   int stall_left = 0;
   int phase_left = 0;
   bit rsp_calm   = 1'b0;
   int stall_roll;

   always @(posedge clock) begin
      if (phase_left == 0) begin
         rsp_calm   = ($urandom_range(0, 2) == 0);
         phase_left = $urandom_range(50, 300);
      end else begin
         phase_left--;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready  <= 1'b1;
         stall_roll = $urandom_range(0, 99);
         if (!rsp_calm) begin
            if (stall_roll < 20) stall_left = $urandom_range(1, 3);
            else if (stall_roll < 24) stall_left = $urandom_range(10, 40);
         end
      end
   end

   // Response checker. Each accepted response beat is compared with the
   // oldest prediction.
   hmf_rsp_type want_mode;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_modes.size() == 0) begin
            $display("%0t: response beat with none expected: mode_value=%0d mode_count=%0d",
                     $time, rsp_data.mode_value, rsp_data.mode_count);
            error_count++;
         end else begin
            want_mode = expected_modes.pop_front();
            if (rsp_data.mode_value !== want_mode.mode_value) begin
               $display("%0t: mode_value mismatch: expected %0d, actual %0d",
                        $time, want_mode.mode_value, rsp_data.mode_value);
               error_count++;
            end
            if (rsp_data.mode_count !== want_mode.mode_count) begin
               $display("%0t: mode_count mismatch: expected %0d, actual %0d",
                        $time, want_mode.mode_count, rsp_data.mode_count);
               error_count++;
            end
         end
      end
   end

   // Watchdog. It counts the cycles in which neither channel moves a beat.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("** histogram_mode_finder: FAILED **");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Directed table. Each row sends one key a given number of times. Only
   // the last beat of a row carries the row's last_item flag. Where a row
   // has an obvious answer, that answer is typed in. All other rows are
   // checked against the predictor.
   // ---------------------------------------------------------------------
   typedef struct packed {
      logic [KEY_FIELD_BITS-1:0]   key_value;
      logic                        last_item;
      int                          repeats;
      logic                        typed;
      logic [KEY_FIELD_BITS-1:0]   want_value;
      logic [COUNT_FIELD_BITS-1:0] want_count;
   } key_row_type;

   localparam int DIRECTED_ROWS = 19;

   key_row_type directed_rows [DIRECTED_ROWS] = '{
      // The first set after reset holds key zero alone.
      '{8'd0,   1'b1, 1,     1'b1, 8'd0,   16'd1},
      // The highest key.
      '{8'd255, 1'b1, 1,     1'b1, 8'd255, 16'd1},
      // Two keys with one hit each. The smaller key wins the tie.
      '{8'd200, 1'b0, 1,     1'b0, 8'd0,   16'd0},
      '{8'd100, 1'b1, 1,     1'b1, 8'd100, 16'd1},
      // Interleaved repeats that end in a tie at two.
      '{8'd9,   1'b0, 1,     1'b0, 8'd0,   16'd0},
      '{8'd5,   1'b0, 1,     1'b0, 8'd0,   16'd0},
      '{8'd9,   1'b0, 1,     1'b0, 8'd0,   16'd0},
      '{8'd5,   1'b1, 1,     1'b0, 8'd0,   16'd0},
      // A later key takes the lead, then the smaller key catches up and wins the tie.
      '{8'd10,  1'b0, 1,     1'b0, 8'd0,   16'd0},
      '{8'd20,  1'b0, 2,     1'b0, 8'd0,   16'd0},
      '{8'd10,  1'b1, 1,     1'b0, 8'd0,   16'd0},
      // Alternating bit patterns in the key.
      '{8'hAA,  1'b0, 1,     1'b0, 8'd0,   16'd0},
      '{8'h55,  1'b0, 2,     1'b0, 8'd0,   16'd0},
      '{8'hAA,  1'b1, 1,     1'b0, 8'd0,   16'd0},
      // A long run of one key builds a large count.
      '{8'd7,   1'b0, 40,    1'b0, 8'd0,   16'd0},
      '{8'd7,   1'b1, 1,     1'b1, 8'd7,   16'd41},
      // The store must be clear again after the long set.
      '{8'd3,   1'b1, 1,     1'b1, 8'd3,   16'd1},
      // The leader holds while a closing key with a single hit arrives.
      '{8'd128, 1'b0, 3,     1'b0, 8'd0,   16'd0},
      '{8'd1,   1'b1, 1,     1'b0, 8'd0,   16'd0}
   };

   initial begin
      hmf_req_type beat;
      hmf_rsp_type typed_mode;
      int          keys_sent;
      int          set_len;
      int          roll;
      int          base_key;
      bit          clustered;

      clear_tally();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         typed_mode.mode_value = directed_rows[r].want_value;
         typed_mode.mode_count = directed_rows[r].want_count;
         // Long rows go back to back.
         sender_calm = (directed_rows[r].repeats > 16);
         for (int n = 0; n < directed_rows[r].repeats; n++) begin
            beat.key_value = directed_rows[r].key_value;
            beat.last_item = directed_rows[r].last_item
                             && (n == directed_rows[r].repeats - 1);
            send_key(beat, pick_gap(), directed_rows[r].typed && beat.last_item,
                     typed_mode);
         end
      end

      // Random sets. Most sets are short, some are medium and a few are long.
      // Half the sets draw keys from a small cluster, so that repeats and
      // ties are common. The other half draw from the full key range.
      keys_sent = 0;
      while (keys_sent < RANDOM_KEYS) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) set_len = $urandom_range(1, 8);
         else if (roll < 95) set_len = $urandom_range(9, 30);
         else set_len = $urandom_range(31, 80);
         clustered   = ($urandom_range(0, 1) == 1);
         base_key    = $urandom_range(0, 255);
         sender_calm = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < set_len; n++) begin
            if (clustered) beat.key_value = 8'((base_key + $urandom_range(0, 3)) % KEY_DEPTH);
            else beat.key_value = 8'($urandom_range(0, 255));
            beat.last_item = (n == set_len - 1);
            send_key(beat, pick_gap(), 1'b0, typed_mode);
         end
         keys_sent += set_len;
      end
      req_valid <= 1'b0;

      while (expected_modes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("** histogram_mode_finder: PASSED **");
      end else begin
         $display("** histogram_mode_finder: FAILED **");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/hmf_pkg.sv
sv/hmf_ctrl.sv
sv/hmf_datapath.sv
sv/histogram_mode_finder.sv
tb/sv/histogram_mode_finder_tb.sv
